FILE: hw/rtl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants of the GUID text parser
// Payload structs, character codes, classifier result type and space table.
// ----------------------------------------------------------------------------
package gtp_pkg;

  typedef struct packed {
    logic [15:0] char_code;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  format_used;
    logic [31:0] part_one;
    logic [15:0] part_two;
    logic [15:0] part_three;
    logic [63:0] tail_bytes;
  } out_item_t;

  // Classification of one character, handed from the classifier to the parser.
  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic [3:0] nibble;
  } char_class_t;

  localparam logic [15:0] CH_DASH   = 16'h002D;
  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_RBRACE = 16'h007D;
  localparam logic [15:0] CH_LPAREN = 16'h0028;
  localparam logic [15:0] CH_RPAREN = 16'h0029;
  localparam logic [15:0] CH_COMMA  = 16'h002C;
  localparam logic [15:0] CH_ZERO   = 16'h0030;
  localparam logic [15:0] CH_LOW_X  = 16'h0078;
  localparam logic [15:0] CH_UP_X   = 16'h0058;

  localparam logic [1:0] FMT_DASHED = 2'd0;
  localparam logic [1:0] FMT_LIST   = 2'd1;
  localparam logic [1:0] FMT_PLAIN  = 2'd2;

  localparam logic [1:0] CLOSER_NONE  = 2'd0;
  localparam logic [1:0] CLOSER_BRACE = 2'd1;
  localparam logic [1:0] CLOSER_PAREN = 2'd2;

  localparam logic [2:0] PH_OPEN   = 3'd0;
  localparam logic [2:0] PH_ZERO   = 3'd1;
  localparam logic [2:0] PH_X      = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_BRACE  = 3'd4;
  localparam logic [2:0] PH_CLOSE  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam int SPACE_COUNT = 26;
  localparam logic [15:0] SPACE_CODES [SPACE_COUNT] = '{
    16'h0020, 16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002, 16'h2003, 16'h2004,
    16'h2005, 16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A, 16'h202F, 16'h205F,
    16'h3000, 16'h2028, 16'h2029, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D,
    16'h0085, 16'h00A0
  };

endpackage

FILE: hw/rtl/gtp_classify.sv
// ----------------------------------------------------------------------------
// gtp_classify: character classifier
// Flags whitespace and hex digits and gives the digit value.
// ----------------------------------------------------------------------------
module gtp_classify (
  input  logic [15:0]         char_code,
  output gtp_pkg::char_class_t cls
);

  always_comb begin
    cls = '0;
    for (int i = 0; i < gtp_pkg::SPACE_COUNT; i++) begin
      if (char_code == gtp_pkg::SPACE_CODES[i]) cls.is_space = 1'b1;
    end
    if (char_code >= 16'h0030 && char_code <= 16'h0039) begin
      cls.is_digit = 1'b1;
      cls.nibble   = 4'(char_code - 16'h0030);
    end else if (char_code >= 16'h0061 && char_code <= 16'h0066) begin
      cls.is_digit = 1'b1;
      cls.nibble   = 4'(char_code - 16'h0057);
    end else if (char_code >= 16'h0041 && char_code <= 16'h0046) begin
      cls.is_digit = 1'b1;
      cls.nibble   = 4'(char_code - 16'h0037);
    end
  end

endmodule

FILE: hw/rtl/guid_text_parser.sv
// ----------------------------------------------------------------------------
// guid_text_parser: streaming GUID string parser for dashed, plain and
// braced hex-list text, one character a cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | payload
//   --------+----------------------------------+----------------------------
//   input   | in_valid, in_ready, in_data      | char_code, last
//   output  | out_valid, out_ready, out_data   | status, format, four fields
//
// One character is taken every cycle unless stalled; per character only
// small counters and registers, a 128-bit nibble shift register and a
// 128-bit list accumulator change. A result enters the output register
// after the character carrying last leaves the input register. The output
// register holds while out_ready is low; only a staged last character then
// stalls the input. Reset (rst, synchronous) clears all parser state.
//
module guid_text_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gtp_pkg::out_item_t  out_data
);

  // Input register.
  logic              in_full;
  gtp_pkg::in_item_t in_reg;

  // Parser state.
  logic saw_dash, saw_open_brace, content_started, trailing_space_seen, string_ended;
  logic [5:0]  dashed_position;
  logic [1:0]  dashed_closer;
  logic        dashed_failed;
  logic [5:0]  plain_count;
  logic        plain_failed;
  logic [127:0] digit_acc;
  logic [2:0]  list_phase;
  logic [3:0]  list_field;
  logic [3:0]  list_significant;
  logic        list_any_digit;
  logic        list_failed;
  logic [31:0] list_value;
  logic [127:0] list_acc;

  gtp_pkg::char_class_t cls;
  logic stage_go;

  gtp_classify u_classify (.char_code(in_reg.char_code), .cls(cls));

  // The staged character moves on unless it closes a string while the
  // output register is still occupied.
  assign stage_go = in_full && !(in_reg.last && out_valid && !out_ready);
  assign in_ready = !in_full || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
      if (in_valid) in_reg <= in_data;
    end
  end

  // Next-state logic for one character.
  logic s_dash, s_brace, s_started, s_trail, s_ended;
  logic [5:0]  d_pos;
  logic [1:0]  d_closer;
  logic        d_fail;
  logic [5:0]  p_cnt;
  logic        p_fail;
  logic [127:0] d_acc;
  logic [2:0]  l_phase;
  logic [3:0]  l_field;
  logic [3:0]  l_sig;
  logic        l_any;
  logic        l_fail;
  logic [31:0] l_val;
  logic [127:0] l_acc;
  logic [3:0]  l_limit;
  logic [3:0]  l_sig_inc;
  logic        dash_slot;
  logic [15:0] want;
  logic [15:0] c;
  logic [3:0]  tail_idx;

  always_comb begin
    c = in_reg.char_code;
    s_dash = saw_dash; s_brace = saw_open_brace; s_started = content_started;
    s_trail = trailing_space_seen; s_ended = string_ended;
    d_pos = dashed_position; d_closer = dashed_closer; d_fail = dashed_failed;
    p_cnt = plain_count; p_fail = plain_failed; d_acc = digit_acc;
    l_phase = list_phase; l_field = list_field; l_sig = list_significant;
    l_any = list_any_digit; l_fail = list_failed; l_val = list_value; l_acc = list_acc;
    l_limit = (list_field == 4'd0) ? 4'd8 : ((list_field <= 4'd2) ? 4'd4 : 4'd2);
    l_sig_inc = list_significant + 4'd1;
    dash_slot = (dashed_position == 6'd8) || (dashed_position == 6'd13) ||
                (dashed_position == 6'd18) || (dashed_position == 6'd23);
    want = (dashed_closer == gtp_pkg::CLOSER_BRACE) ? gtp_pkg::CH_RBRACE
                                                    : gtp_pkg::CH_RPAREN;
    tail_idx = 4'd10 - list_field;
    if (!string_ended) begin
      if (c == 16'd0) begin
        s_ended = 1'b1;
      end else if (cls.is_space) begin
        if (content_started) s_trail = 1'b1;
      end else begin
        if (c == gtp_pkg::CH_DASH) s_dash = 1'b1;
        if (c == gtp_pkg::CH_LBRACE) s_brace = 1'b1;
        // Hex-list grammar.
        if (!list_failed) begin
          unique case (list_phase)
            gtp_pkg::PH_OPEN: begin
              if (c == gtp_pkg::CH_LBRACE) l_phase = gtp_pkg::PH_ZERO; else l_fail = 1'b1;
            end
            gtp_pkg::PH_ZERO: begin
              if (c == gtp_pkg::CH_ZERO) l_phase = gtp_pkg::PH_X; else l_fail = 1'b1;
            end
            gtp_pkg::PH_X: begin
              if (c == gtp_pkg::CH_LOW_X || c == gtp_pkg::CH_UP_X) begin
                l_phase = gtp_pkg::PH_DIGITS; l_sig = '0; l_any = 1'b0; l_val = '0;
              end else begin
                l_fail = 1'b1;
              end
            end
            gtp_pkg::PH_DIGITS: begin
              if (cls.is_digit) begin
                l_any = 1'b1;
                if (list_significant != 4'd0 || cls.nibble != 4'd0) begin
                  l_sig = l_sig_inc;
                  if (l_sig_inc > l_limit) l_fail = 1'b1;
                end
                if (!l_fail) l_val = {list_value[27:0], cls.nibble};
              end else if (!list_any_digit) begin
                l_fail = 1'b1;
              end else begin
                if (list_field == 4'd0) l_acc[127:96] = l_acc[127:96] | list_value;
                else if (list_field == 4'd1) l_acc[95:80] = l_acc[95:80] | list_value[15:0];
                else if (list_field == 4'd2) l_acc[79:64] = l_acc[79:64] | list_value[15:0];
                else if (list_field <= 4'd10)
                  l_acc[63:0] = l_acc[63:0] | (64'(list_value[7:0]) << {tail_idx, 3'b000});
                if (list_field >= 4'd10) begin
                  if (c == gtp_pkg::CH_RBRACE) l_phase = gtp_pkg::PH_CLOSE; else l_fail = 1'b1;
                end else if (c == gtp_pkg::CH_COMMA) begin
                  l_phase = (list_field == 4'd2) ? gtp_pkg::PH_BRACE : gtp_pkg::PH_ZERO;
                  l_field = list_field + 4'd1;
                end else begin
                  l_fail = 1'b1;
                end
              end
            end
            gtp_pkg::PH_BRACE: begin
              if (c == gtp_pkg::CH_LBRACE) l_phase = gtp_pkg::PH_ZERO; else l_fail = 1'b1;
            end
            gtp_pkg::PH_CLOSE: begin
              if (c == gtp_pkg::CH_RBRACE) l_phase = gtp_pkg::PH_DONE; else l_fail = 1'b1;
            end
            default: l_fail = 1'b1;
          endcase
        end
        if (trailing_space_seen) begin
          d_fail = 1'b1;
          p_fail = 1'b1;
        end
        s_started = 1'b1;
        if (cls.is_digit) d_acc = {digit_acc[123:0], cls.nibble};
        // Dashed grammar.
        if (!content_started && (c == gtp_pkg::CH_LBRACE || c == gtp_pkg::CH_LPAREN)) begin
          d_closer = (c == gtp_pkg::CH_LBRACE) ? gtp_pkg::CLOSER_BRACE
                                               : gtp_pkg::CLOSER_PAREN;
        end else if (!d_fail) begin
          if (dashed_position < 6'd36) begin
            if (dash_slot ? (c == gtp_pkg::CH_DASH) : cls.is_digit)
              d_pos = dashed_position + 6'd1;
            else
              d_fail = 1'b1;
          end else if (dashed_position == 6'd36 && dashed_closer != gtp_pkg::CLOSER_NONE) begin
            if (c == want) d_pos = 6'd37; else d_fail = 1'b1;
          end else begin
            d_fail = 1'b1;
          end
        end
        // Plain grammar.
        if (!p_fail) begin
          if (cls.is_digit && plain_count < 6'd32) p_cnt = plain_count + 6'd1;
          else p_fail = 1'b1;
        end
      end
    end
  end

  // Result selection for a closing character.
  gtp_pkg::out_item_t result;
  logic ok;
  logic [127:0] src;

  always_comb begin
    if (s_dash) begin
      result.format_used = gtp_pkg::FMT_DASHED;
      ok  = !d_fail && (d_pos == ((d_closer != gtp_pkg::CLOSER_NONE) ? 6'd37 : 6'd36));
      src = d_acc;
    end else if (s_brace) begin
      result.format_used = gtp_pkg::FMT_LIST;
      ok  = !l_fail && (l_phase == gtp_pkg::PH_DONE);
      src = l_acc;
    end else begin
      result.format_used = gtp_pkg::FMT_PLAIN;
      ok  = !p_fail && (p_cnt == 6'd32);
      src = d_acc;
    end
    if (!ok) src = '0;
    result.status     = !ok;
    result.part_one   = src[127:96];
    result.part_two   = src[95:80];
    result.part_three = src[79:64];
    result.tail_bytes = src[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (stage_go && in_reg.last)) begin
      saw_dash <= 1'b0; saw_open_brace <= 1'b0; content_started <= 1'b0;
      trailing_space_seen <= 1'b0; string_ended <= 1'b0;
      dashed_position <= '0; dashed_closer <= gtp_pkg::CLOSER_NONE; dashed_failed <= 1'b0;
      plain_count <= '0; plain_failed <= 1'b0; digit_acc <= '0;
      list_phase <= gtp_pkg::PH_OPEN; list_field <= '0; list_significant <= '0;
      list_any_digit <= 1'b0; list_failed <= 1'b0; list_value <= '0; list_acc <= '0;
    end else if (stage_go) begin
      saw_dash <= s_dash; saw_open_brace <= s_brace; content_started <= s_started;
      trailing_space_seen <= s_trail; string_ended <= s_ended;
      dashed_position <= d_pos; dashed_closer <= d_closer; dashed_failed <= d_fail;
      plain_count <= p_cnt; plain_failed <= p_fail; digit_acc <= d_acc;
      list_phase <= l_phase; list_field <= l_field; list_significant <= l_sig;
      list_any_digit <= l_any; list_failed <= l_fail; list_value <= l_val; list_acc <= l_acc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && in_reg.last) begin
      out_valid <= 1'b1;
      out_data  <= result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/gtp_checker.sv
// ----------------------------------------------------------------------------
// gtp_checker: port-level assertions for the GUID text parser
// Watches the top-level handshakes and result encoding.
// ----------------------------------------------------------------------------
module gtp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input gtp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input gtp_pkg::out_item_t out_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A failed parse reports all-zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.part_one == 32'd0 &&
      out_data.part_two == 16'd0 && out_data.part_three == 16'd0 &&
      out_data.tail_bytes == 64'd0)
    else $error("failed parse carries data");

  // Format code is one of the three defined codes.
  a_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.format_used == gtp_pkg::FMT_DASHED ||
      out_data.format_used == gtp_pkg::FMT_LIST ||
      out_data.format_used == gtp_pkg::FMT_PLAIN)
    else $error("bad format code");

  // With the output register empty nothing can hold the input back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A waiting input transaction keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

endmodule

bind guid_text_parser gtp_checker u_gtp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
